// ----- rtl/core/tbt_pkg.sv -----
// shared types and constants for the triangle tangent/bitangent block
package tbt_pkg;

  // position of the vertex that closes a triangle
  localparam logic [1:0] SLOT_THIRD = 2'd2;

  // number of held coordinates and of delta words per triangle
  localparam int NUM_HELD  = 10;
  localparam int NUM_DELTA = 10;

  // product pair index: determinant first, then six vector components
  localparam logic [2:0] K_DET  = 3'd0;
  localparam logic [2:0] K_LAST = 3'd6;

  // result copies per triangle
  localparam logic [1:0] NUM_COPIES = 2'd3;

  // back end sequencer states
  typedef enum logic [1:0] {
    B_IDLE,
    B_MUL,
    B_DIV,
    B_OUT
  } back_state_t;

  // control from back end to result stage
  typedef struct packed {
    logic load;
    logic degen;
  } res_ctl_t;

endpackage

// ----- rtl/core/tbt_queue.sv -----
// small request queue between the front end and the back end
module tbt_queue
  import tbt_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             q_full,
  output logic             q_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [AW:0]      count;

  assign q_full  = (count == (AW+1)'(DEPTH));
  assign q_empty = (count == '0);
  assign rdata   = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr && !q_full) begin
      mem[wptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr && !q_full) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      end
      if (rd && !q_empty) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      end
      case ({wr && !q_full, rd && !q_empty})
        2'b10:   count <= count + (AW+1)'(1);
        2'b01:   count <= count - (AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/core/tbt_front.sv -----
// front end: holds the first two vertices and forms the triangle deltas
module tbt_front
  import tbt_pkg::*;
#(
  parameter int W  = 32,
  parameter int MW = W + 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  logic signed [W-1:0]     pos_x,
  input  logic signed [W-1:0]     pos_y,
  input  logic signed [W-1:0]     pos_z,
  input  logic signed [W-1:0]     tex_u,
  input  logic signed [W-1:0]     tex_v,
  input  logic                    q_full,
  output logic                    job_push,
  output logic [NUM_DELTA*MW-1:0] job_data
);

  logic [1:0]   slot;
  logic [1:0]   slot_next;
  logic [W-1:0] hv [NUM_HELD];
  logic [W-1:0] vin [5];
  logic         accept;

  assign vin[0] = pos_x;
  assign vin[1] = pos_y;
  assign vin[2] = pos_z;
  assign vin[3] = tex_u;
  assign vin[4] = tex_v;

  assign full     = (slot == SLOT_THIRD) && q_full;
  assign accept   = push && !full;
  assign job_push = accept && (slot == SLOT_THIRD);

  function automatic logic [MW-1:0] dsub(input logic [W-1:0] a, input logic [W-1:0] b);
    dsub = {a[W-1], a} - {b[W-1], b};
  endfunction

  // exact deltas: dp1, dp2, then du1 dv1 du2 dv2
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      job_data[i*MW +: MW]     = dsub(hv[5+i], hv[i]);
      job_data[(3+i)*MW +: MW] = dsub(vin[i], hv[i]);
    end
    job_data[6*MW +: MW] = dsub(hv[8], hv[3]);
    job_data[7*MW +: MW] = dsub(hv[9], hv[4]);
    job_data[8*MW +: MW] = dsub(vin[3], hv[3]);
    job_data[9*MW +: MW] = dsub(vin[4], hv[4]);
  end

  // held vertices
  always_ff @(posedge clk) begin
    if (accept && slot == 2'd0) begin
      for (int i = 0; i < 5; i++) hv[i] <= vin[i];
    end
    if (accept && slot == 2'd1) begin
      for (int i = 0; i < 5; i++) hv[5+i] <= vin[i];
    end
  end

  // vertex position within triangle
  always_comb begin
    slot_next = slot;
    if (accept) begin
      slot_next = (slot == SLOT_THIRD) ? 2'd0 : slot + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= 2'd0;
    end else begin
      slot <= slot_next;
    end
  end

endmodule

// ----- rtl/core/tbt_back.sv -----
// back end: serial multiplier and divider for determinant and vectors
module tbt_back
  import tbt_pkg::*;
#(
  parameter int W  = 32,
  parameter int F  = 16,
  parameter int MW = W + 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    job_valid,
  input  logic [NUM_DELTA*MW-1:0] job_in,
  output logic                    job_pop,
  input  logic                    out_ready,
  output res_ctl_t                res_ctl,
  output logic [6*W-1:0]          res_vec
);

  localparam int PW = 2 * MW + 1;
  localparam int NW = PW + F + 2;
  localparam int CW = $clog2(NW + 2);

  back_state_t state;
  back_state_t state_next;

  logic [NUM_DELTA*MW-1:0] job;
  logic [2:0]      k;
  logic            phase;
  logic [CW-1:0]   cnt;
  logic [2*MW-1:0] mcand;
  logic [MW-1:0]   mplier;
  logic [2*MW-1:0] acc;
  logic            mneg;
  logic [PW-1:0]   pa;
  logic [PW-1:0]   md;
  logic            dneg;
  logic            degen;
  logic [NW-1:0]   dvd;
  logic [NW-1:0]   quo;
  logic [PW:0]     rem;
  logic            qneg;
  logic [W-1:0]    res [6];

  logic [MW-1:0]   opx;
  logic [MW-1:0]   opy;
  logic [MW-1:0]   ax;
  logic [MW-1:0]   ay;
  logic [2:0]      c;
  logic [2:0]      ax_i;
  logic [PW-1:0]   prod_s;
  logic [PW-1:0]   num;
  logic [PW-1:0]   mn;
  logic [PW+1:0]   rem_sh;
  logic [PW+1:0]   dvs;
  logic [NW-1:0]   lim;
  logic [NW-1:0]   sat_v;
  logic [W-1:0]    sat_r;
  logic            mul_fin;
  logic            div_fin;

  function automatic logic [MW-1:0] dsel(input logic [NUM_DELTA*MW-1:0] j,
                                         input int idx);
    dsel = j[idx*MW +: MW];
  endfunction

  // operand select for the current product pair
  always_comb begin
    c    = k - 3'd1;
    ax_i = (c >= 3'd3) ? c - 3'd3 : c;
    opx  = '0;
    opy  = '0;
    if (k == K_DET) begin
      opx = phase ? dsel(job, 7) : dsel(job, 6);
      opy = phase ? dsel(job, 8) : dsel(job, 9);
    end else if (c < 3'd3) begin
      opx = phase ? dsel(job, 3 + int'(ax_i)) : dsel(job, int'(ax_i));
      opy = phase ? dsel(job, 7) : dsel(job, 9);
    end else begin
      opx = phase ? dsel(job, int'(ax_i)) : dsel(job, 3 + int'(ax_i));
      opy = phase ? dsel(job, 8) : dsel(job, 6);
    end
    ax = opx[MW-1] ? -opx : opx;
    ay = opy[MW-1] ? -opy : opy;
  end

  // signed product, pair difference and its magnitude
  always_comb begin
    prod_s = mneg ? -PW'(acc) : PW'(acc);
    num    = pa - prod_s;
    mn     = num[PW-1] ? -num : num;
  end

  // divider step and saturation
  always_comb begin
    rem_sh = {rem, dvd[NW-1]};
    dvs    = {1'b0, md, 1'b0};
    lim    = NW'(1) << (W - 1);
    if (qneg) begin
      sat_v = (quo > lim) ? lim : quo;
    end else begin
      sat_v = (quo > lim - NW'(1)) ? lim - NW'(1) : quo;
    end
    sat_r = qneg ? -sat_v[W-1:0] : sat_v[W-1:0];
  end

  assign mul_fin = (state == B_MUL) && (cnt == CW'(MW + 1));
  assign div_fin = (state == B_DIV) && (cnt == CW'(NW));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (job_valid) state_next = B_MUL;
      B_MUL: begin
        if (mul_fin && phase) begin
          if (k == K_DET) begin
            state_next = (num == '0) ? B_OUT : B_MUL;
          end else begin
            state_next = B_DIV;
          end
        end
      end
      B_DIV: if (div_fin) state_next = (k == K_LAST) ? B_OUT : B_MUL;
      B_OUT: if (out_ready) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    job_pop       = 1'b0;
    res_ctl.load  = 1'b0;
    res_ctl.degen = degen;
    unique case (state)
      B_IDLE:  job_pop = job_valid;
      B_OUT:   res_ctl.load = out_ready;
      default: job_pop = 1'b0;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      res_vec[i*W +: W] = degen ? '0 : res[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer counters
  always_ff @(posedge clk) begin
    if (rst) begin
      k     <= K_DET;
      phase <= 1'b0;
      cnt   <= '0;
    end else begin
      case (state)
        B_IDLE: begin
          k     <= K_DET;
          phase <= 1'b0;
          cnt   <= '0;
        end
        B_MUL: begin
          if (mul_fin) begin
            cnt <= '0;
            if (!phase) begin
              phase <= 1'b1;
            end else begin
              phase <= 1'b0;
              if (k == K_DET) k <= k + 3'd1;
            end
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        B_DIV: begin
          if (div_fin) begin
            cnt <= '0;
            k   <= k + 3'd1;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        default: cnt <= '0;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state == B_IDLE && job_valid) begin
      job <= job_in;
    end
    if (state == B_MUL) begin
      if (cnt == '0) begin
        mcand  <= (2*MW)'(ax);
        mplier <= ay;
        acc    <= '0;
        mneg   <= opx[MW-1] ^ opy[MW-1];
      end else if (!mul_fin) begin
        if (mplier[0]) acc <= acc + mcand;
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
      end else if (!phase) begin
        pa <= prod_s;
      end else if (k == K_DET) begin
        md    <= mn;
        dneg  <= num[PW-1];
        degen <= (num == '0);
      end else begin
        dvd  <= (NW'(mn) << (F + 1)) + NW'(md);
        quo  <= '0;
        rem  <= '0;
        qneg <= num[PW-1] ^ dneg;
      end
    end
    if (state == B_DIV) begin
      if (div_fin) begin
        res[k - 3'd1] <= sat_r;
      end else begin
        dvd <= dvd << 1;
        if (rem_sh >= dvs) begin
          rem <= (PW+1)'(rem_sh - dvs);
          quo <= {quo[NW-2:0], 1'b1};
        end else begin
          rem <= rem_sh[PW:0];
          quo <= {quo[NW-2:0], 1'b0};
        end
      end
    end
  end

endmodule

// ----- rtl/core/tbt_out.sv -----
// result stage: holds one triangle's vectors and replays them per vertex
module tbt_out
  import tbt_pkg::*;
#(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  res_ctl_t            res_ctl,
  input  logic [6*W-1:0]      res_vec,
  output logic                out_ready,
  output logic                empty,
  input  logic                pop,
  output logic signed [W-1:0] tangent_x,
  output logic signed [W-1:0] tangent_y,
  output logic signed [W-1:0] tangent_z,
  output logic signed [W-1:0] bitangent_x,
  output logic signed [W-1:0] bitangent_y,
  output logic signed [W-1:0] bitangent_z,
  output logic                degenerate,
  output logic                last_copy
);

  logic [1:0]     copies;
  logic [6*W-1:0] vec;
  logic           dg;

  assign out_ready   = (copies == 2'd0);
  assign empty       = (copies == 2'd0);
  assign last_copy   = (copies == 2'd1);
  assign degenerate  = dg;
  assign tangent_x   = vec[0*W +: W];
  assign tangent_y   = vec[1*W +: W];
  assign tangent_z   = vec[2*W +: W];
  assign bitangent_x = vec[3*W +: W];
  assign bitangent_y = vec[4*W +: W];
  assign bitangent_z = vec[5*W +: W];

  // result payload
  always_ff @(posedge clk) begin
    if (res_ctl.load && out_ready) begin
      vec <= res_vec;
      dg  <= res_ctl.degen;
    end
  end

  // remaining copies
  always_ff @(posedge clk) begin
    if (rst) begin
      copies <= 2'd0;
    end else if (res_ctl.load && out_ready) begin
      copies <= NUM_COPIES;
    end else if (pop && !empty) begin
      copies <= copies - 2'd1;
    end
  end

endmodule

// ----- rtl/core/triangle_tangent_bitangent.sv -----
// top level of the triangle tangent/bitangent block
//
//   channel  | handshake    | payload
//   ---------+--------------+-----------------------------------------------
//   vertex   | push / full  | pos_x pos_y pos_z tex_u tex_v
//   result   | pop / empty  | tangent_xyz bitangent_xyz degenerate last_copy
//
// the first two vertices of a triangle are taken without waiting; the third
// is taken once the two-entry delta queue has room. the back end forms each
// product pair in its serial multiplier and each component in its serial
// divider, so a triangle costs about 7 pairs plus 6 divisions, then three
// result pops.
// reset is synchronous and clears only control state. either side may stall
// freely; the queue lets the front end keep taking vertices meanwhile.
module triangle_tangent_bitangent
  import tbt_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic signed [COORD_WIDTH-1:0] pos_x,
  input  logic signed [COORD_WIDTH-1:0] pos_y,
  input  logic signed [COORD_WIDTH-1:0] pos_z,
  input  logic signed [COORD_WIDTH-1:0] tex_u,
  input  logic signed [COORD_WIDTH-1:0] tex_v,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [COORD_WIDTH-1:0] tangent_x,
  output logic signed [COORD_WIDTH-1:0] tangent_y,
  output logic signed [COORD_WIDTH-1:0] tangent_z,
  output logic signed [COORD_WIDTH-1:0] bitangent_x,
  output logic signed [COORD_WIDTH-1:0] bitangent_y,
  output logic signed [COORD_WIDTH-1:0] bitangent_z,
  output logic                          degenerate,
  output logic                          last_copy
);

  localparam int MW = COORD_WIDTH + 1;
  localparam int JW = NUM_DELTA * MW;

  logic                   job_push;
  logic [JW-1:0]          job_wdata;
  logic [JW-1:0]          job_rdata;
  logic                   job_pop;
  logic                   q_full;
  logic                   q_empty;
  logic                   out_ready;
  res_ctl_t               res_ctl;
  logic [6*COORD_WIDTH-1:0] res_vec;

  // vertex intake and deltas
  tbt_front #(.W(COORD_WIDTH), .MW(MW)) u_front (
    .clk, .rst, .push, .full,
    .pos_x, .pos_y, .pos_z, .tex_u, .tex_v,
    .q_full,
    .job_push,
    .job_data (job_wdata)
  );

  // delta queue
  tbt_queue #(.WIDTH(JW), .DEPTH(2)) u_queue (
    .clk, .rst,
    .wr      (job_push),
    .wdata   (job_wdata),
    .rd      (job_pop),
    .rdata   (job_rdata),
    .q_full,
    .q_empty
  );

  // arithmetic back end
  tbt_back #(.W(COORD_WIDTH), .F(FRAC_BITS), .MW(MW)) u_back (
    .clk, .rst,
    .job_valid (!q_empty),
    .job_in    (job_rdata),
    .job_pop,
    .out_ready,
    .res_ctl,
    .res_vec
  );

  // result replay
  tbt_out #(.W(COORD_WIDTH)) u_out (
    .clk, .rst,
    .res_ctl, .res_vec,
    .out_ready,
    .empty, .pop,
    .tangent_x, .tangent_y, .tangent_z,
    .bitangent_x, .bitangent_y, .bitangent_z,
    .degenerate, .last_copy
  );

  // degenerate triangles carry zero vectors
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && degenerate) |-> (tangent_x == '0 && tangent_y == '0 && tangent_z == '0 &&
      bitangent_x == '0 && bitangent_y == '0 && bitangent_z == '0))
    else $error("degenerate result with nonzero vector");

  // queue cannot be full and empty at once
  a_queue_sane: assert property (@(posedge clk) disable iff (rst)
    !(q_full && q_empty))
    else $error("delta queue full and empty together");

  // taking the last copy drains the result stage
  a_last_drain: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && last_copy) |=> empty)
    else $error("result stage not drained after last copy");

endmodule

// ----- sim/tb_triangle_tangent_bitangent.sv -----
// testbench for the triangle tangent/bitangent block: random vertex stream checked by a scoreboard
`timescale 1ns / 1ps

module tb_triangle_tangent_bitangent;

  localparam int CW        = 32;
  localparam int FB        = 16;
  localparam int MAX_CYC   = 3000000;
  localparam int HOLD_CYC  = 6000;
  localparam int RAND_TRIS = 145;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic [2:0][CW-1:0] tang;
    logic [2:0][CW-1:0] bitan;
    logic               degen;
    logic               last;
  } frame_t;

  // scoreboard: tangent-frame predictor plus queue of pending results
  class frame_scoreboard;
    wide_t  held [2][5];
    int     slot;
    frame_t pending_frames[$];
    int     mismatches;

    function new();
      slot = 0;
      mismatches = 0;
    endfunction

    // round(num * 2^FB / det) ties away from zero, saturated
    function logic [CW-1:0] scaled_quot(wide_t num, wide_t den);
      logic        neg;
      logic [127:0] mn, md, q;
      logic [127:0] lim;
      if (num == 0) return '0;
      neg = (num < 0) != (den < 0);
      mn  = (num < 0) ? -num : num;
      md  = (den < 0) ? -den : den;
      q   = ((mn << (FB + 1)) + md) / (md << 1);
      lim = 128'd1 << (CW - 1);
      if (neg) begin
        if (q > lim) q = lim;
        return -q[CW-1:0];
      end
      if (q > lim - 1) q = lim - 1;
      return q[CW-1:0];
    endfunction

    // note one accepted vertex request
    function void note_vertex(logic [4:0][CW-1:0] vtx);
      wide_t  cur [5];
      wide_t  dp1 [3];
      wide_t  dp2 [3];
      wide_t  du1, dv1, du2, dv2, det;
      frame_t f;
      for (int i = 0; i < 5; i++) cur[i] = wide_t'(signed'(vtx[i]));
      if (slot < 2) begin
        held[slot] = cur;
        slot++;
        return;
      end
      slot = 0;
      for (int i = 0; i < 3; i++) begin
        dp1[i] = held[1][i] - held[0][i];
        dp2[i] = cur[i] - held[0][i];
      end
      du1 = held[1][3] - held[0][3];
      dv1 = held[1][4] - held[0][4];
      du2 = cur[3] - held[0][3];
      dv2 = cur[4] - held[0][4];
      det = du1 * dv2 - dv1 * du2;
      f = '0;
      f.degen = (det == 0);
      if (!f.degen) begin
        for (int i = 0; i < 3; i++) begin
          f.tang[i]  = scaled_quot(dp1[i] * dv2 - dp2[i] * dv1, det);
          f.bitan[i] = scaled_quot(dp2[i] * du1 - dp1[i] * du2, det);
        end
      end
      for (int k = 0; k < 3; k++) begin
        f.last = (k == 2);
        pending_frames.insert(pending_frames.size(), f);
      end
    endfunction

    // compare one popped result with the oldest expectation
    function void check_frame(frame_t act);
      frame_t exp_f;
      if (pending_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", act);
        return;
      end
      exp_f = pending_frames.pop_front();
      if (act !== exp_f) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result mismatch at %0t", $realtime);
          for (int i = 0; i < 3; i++)
            $display("  tang[%0d] exp %h act %h  bitan[%0d] exp %h act %h", i,
                     exp_f.tang[i], act.tang[i], i, exp_f.bitan[i], act.bitan[i]);
          $display("  degen exp %b act %b  last exp %b act %b",
                   exp_f.degen, act.degen, exp_f.last, act.last);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  logic signed [CW-1:0] pos_x = '0, pos_y = '0, pos_z = '0, tex_u = '0, tex_v = '0;
  logic signed [CW-1:0] tangent_x, tangent_y, tangent_z;
  logic signed [CW-1:0] bitangent_x, bitangent_y, bitangent_z;
  logic degenerate, last_copy;

  logic hold_pop = 1'b0;
  logic quiet = 1'b0;
  int   cycles = 0;
  frame_scoreboard sb;

  triangle_tangent_bitangent u_dut (
    .clk, .rst, .push, .full, .pos_x, .pos_y, .pos_z, .tex_u, .tex_v,
    .empty, .pop, .tangent_x, .tangent_y, .tangent_z,
    .bitangent_x, .bitangent_y, .bitangent_z, .degenerate, .last_copy
  );

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYC) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // monitor accepted requests on both sides
  always @(posedge clk) begin
    if (!rst && push && !full)
      sb.note_vertex({tex_v, tex_u, pos_z, pos_y, pos_x});
    if (!rst && pop && !empty)
      sb.check_frame({{tangent_z, tangent_y, tangent_x},
                      {bitangent_z, bitangent_y, bitangent_x}, degenerate, last_copy});
  end

  // result side: random pop idling with an optional long hold
  initial begin
    int gap;
    @(negedge rst);
    @(posedge clk);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 19);
      if (gap > 0 || hold_pop) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
        while (hold_pop) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
    end
  end

  // offer one vertex and wait for acceptance
  task automatic send_vertex(logic [CW-1:0] x, y, z, u, v);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push  <= 1'b1;
    pos_x <= x;
    pos_y <= y;
    pos_z <= z;
    tex_u <= u;
    tex_v <= v;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // random coordinate by value class
  function automatic logic [CW-1:0] rand_coord(int kind);
    case (kind)
      0: return $urandom;
      1: return $urandom_range(0, 1 << 19) - (1 << 18);
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'h7fffffff;
          1: return 32'h80000000;
          2: return 32'hffffffff;
          3: return 32'h00000001;
          default: return 32'h0;
        endcase
      end
    endcase
  endfunction

  // random triangle; degenerate variant repeats the first texture coordinate
  task automatic send_random_triangle();
    int kind;
    logic [CW-1:0] u0, v0;
    kind = $urandom_range(0, 9);
    kind = (kind < 3) ? 0 : (kind < 7) ? 1 : (kind < 9) ? 2 : 3;
    u0 = rand_coord(kind == 3 ? 1 : kind);
    v0 = rand_coord(kind == 3 ? 1 : kind);
    send_vertex(rand_coord(kind % 3), rand_coord(kind % 3), rand_coord(kind % 3), u0, v0);
    for (int i = 0; i < 2; i++) begin
      if (kind == 3)
        send_vertex(rand_coord(1), rand_coord(1), rand_coord(1), u0, $urandom);
      else
        send_vertex(rand_coord(kind), rand_coord(kind), rand_coord(kind),
                    rand_coord(kind), rand_coord(kind));
    end
  endtask

  // main sequence
  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: all zeros, degenerate
    repeat (3) send_vertex(0, 0, 0, 0, 0);
    // unit frame: tangent along x, bitangent along y
    send_vertex(0, 0, 0, 0, 0);
    send_vertex(32'h10000, 0, 0, 32'h10000, 0);
    send_vertex(0, 32'h10000, 0, 0, 32'h10000);
    // huge edges over tiny uv span, saturates positive
    send_vertex(32'h80000000, 32'h80000000, 32'h80000000, 0, 0);
    send_vertex(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1, 0);
    send_vertex(32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 1);
    // extreme uv, negative determinant, saturates both ways
    send_vertex(32'h7fffffff, 0, 32'h80000000, 32'h80000000, 32'h80000000);
    send_vertex(32'h80000000, 32'h7fffffff, 0, 32'h80000000, 32'h80000001);
    send_vertex(0, 32'h80000000, 32'h7fffffff, 32'h80000001, 32'h80000000);
    // flat positions, zero numerators
    send_vertex(32'h12345, 32'h12345, 32'h12345, 32'h7fffffff, 32'h7fffffff);
    send_vertex(32'h12345, 32'h12345, 32'h12345, 32'hffffffff, 32'h3);
    send_vertex(32'h12345, 32'h12345, 32'h12345, 32'h5, 32'h80000000);
    // small edges with det 2, exact quotients
    send_vertex(0, 0, 0, 0, 0);
    send_vertex(32'hffffffff, 1, 32'h3, 1, 0);
    send_vertex(1, 32'hffffffff, 32'h5, 0, 2);
    // all-ones and alternating bit patterns
    send_vertex(32'hffffffff, 32'haaaaaaaa, 32'h55555555, 32'hffffffff, 32'haaaaaaaa);
    send_vertex(32'h55555555, 32'hffffffff, 32'haaaaaaaa, 32'h55555555, 32'hffffffff);
    send_vertex(32'haaaaaaaa, 32'h55555555, 32'hffffffff, 32'haaaaaaaa, 32'h55555555);

    // random triangles, long pop hold early on to back up the input
    fork
      begin
        repeat (200) @(posedge clk);
        hold_pop <= 1'b1;
        repeat (HOLD_CYC) @(posedge clk);
        hold_pop <= 1'b0;
      end
    join_none
    for (int t = 0; t < RAND_TRIS; t++) begin
      quiet = ((t / 12) % 4) == 3;
      send_random_triangle();
    end
    quiet = 1'b0;
    push <= 1'b0;

    // drain
    while (sb.pending_frames.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_frames.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/tbt_pkg.sv
rtl/core/tbt_queue.sv
rtl/core/tbt_front.sv
rtl/core/tbt_back.sv
rtl/core/tbt_out.sv
rtl/core/triangle_tangent_bitangent.sv
sim/tb_triangle_tangent_bitangent.sv
